@@ src/tlat_pkg.sv @@
// shared types and constants for the target lock angle tracker
package tlat_pkg;

    localparam int SIZE_BITS      = 13;
    localparam int FOV_BITS       = 16;
    localparam int ANGLE_BITS     = 17;
    localparam int CMD_BITS       = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int LIMIT_BITS     = 38;

    localparam logic [CMD_BITS-1:0]   ENABLE_WORD = 32'd22110000;
    // 1e9 px^2 in Q.8 px^2
    localparam logic [LIMIT_BITS-1:0] DIST_LIMIT  = 38'd256000000000;
    localparam logic [15:0]           ANGLE_MAX   = 16'd46080;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 13'd1280;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd720;
    localparam logic [FOV_BITS-1:0]  FOV_H_RESET  = 16'd32000;
    localparam logic [FOV_BITS-1:0]  FOV_V_RESET  = 16'd17664;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_FOV_HORIZONTAL = 2'd2,
        CFG_FOV_VERTICAL   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_CMP,
        S_MUL_X,
        S_START_X,
        S_DIV_X,
        S_MUL_Y,
        S_START_Y,
        S_DIV_Y,
        S_EMIT
    } tlat_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ src/tlat_mul.sv @@
// shared registered multiplier used for distances and angle products
module tlat_mul
    import tlat_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic                 clk,
    input  logic [WIDTH-1:0]     a,
    input  logic [WIDTH-1:0]     b,
    output logic [2*WIDTH-1:0]   p
);

    logic [2*WIDTH-1:0] p_reg;
    logic [2*WIDTH-1:0] p_next;

    assign p_next = (2*WIDTH)'(a) * (2*WIDTH)'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

@@ src/tlat_div.sv @@
// restoring divider, one quotient bit per cycle
module tlat_div
    import tlat_pkg::*;
#(
    parameter int N_WIDTH = 29,
    parameter int D_WIDTH = 13
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [N_WIDTH-1:0] dividend,
    input  logic [D_WIDTH-1:0] divisor,
    output logic [N_WIDTH-1:0] quotient,
    output div_status_t        status
);

    localparam int CNT_W = $clog2(N_WIDTH + 1);

    logic [N_WIDTH-1:0] quo_reg, quo_next;
    logic [D_WIDTH-1:0] rem_reg, rem_next;
    logic [D_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [D_WIDTH+1:0] shifted;
    logic [D_WIDTH+1:0] diff;

    always_comb
    begin
        shifted   = (D_WIDTH+2)'({rem_reg, quo_reg[N_WIDTH-1]});
        diff      = shifted - (D_WIDTH+2)'(dvs_reg);
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(N_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // no borrow means the divisor fits
            if (!diff[D_WIDTH+1])
            begin
                rem_next = diff[D_WIDTH-1:0];
                quo_next = {quo_reg[N_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D_WIDTH-1:0];
                quo_next = {quo_reg[N_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ src/target_lock_angle_tracker_unit.sv @@
// target lock angle tracker: top level with sequencer, lock state and output register
//
// Input channel (in_valid / in_stall) carries one beat per detection or command.
// A command beat with the enable word switches tracking on and drops any lock.
// Detection beats are grouped into frames by last_in_frame. Unlocked, a frame
// locks onto the target-class detection nearest the image centre; locked, the
// first detection with the locked id is held and at frame end its offset angles
// are sent on the output channel (out_valid / out_stall) as one beat.
// A command, an ignored detection or a locked detection that is not a frame end
// is taken in the idle state alone; an unlocked target-class detection takes two
// passes through the shared multiplier, then add and compare. A locked frame end
// with a hit takes, per axis, one multiply and then one bit per cycle through
// the shared divider; the angles then wait in S_EMIT for the output register.
// in_stall is high while a beat is being worked on. The output register holds a
// finished beat, so a new input beat is taken while it waits; if the next result
// is ready while the receiver still stalls, the block waits with in_stall high.
// Reset (rst_n, asynchronous) turns tracking off, drops the lock and loads the
// default image size and fields of view; no clearing pass is needed.
module target_lock_angle_tracker_unit
    import tlat_pkg::*;
#(
    parameter int ID_BITS    = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic                        cmd_has_value,
    input  logic signed [CMD_BITS-1:0]  cmd_word,
    input  logic                        is_drone,
    input  logic [ID_BITS-1:0]          track_id,
    input  logic [COORD_BITS-1:0]       center_x,
    input  logic [COORD_BITS-1:0]       center_y,
    input  logic                        last_in_frame,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [ANGLE_BITS-1:0] angle_x,
    output logic signed [ANGLE_BITS-1:0] angle_y
);

    localparam int MAG_BITS = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int OFF_W    = MAG_BITS + 1;
    localparam int PROD_W   = 2 * MAG_BITS;
    localparam int SUM_W    = 2 * MAG_BITS + 1;
    localparam int DIST_W   = (SUM_W > LIMIT_BITS) ? SUM_W : LIMIT_BITS;
    localparam int NUM_W    = MAG_BITS + 17;
    localparam int DIVD_W   = MAG_BITS + 13;

    tlat_state_t state_reg, state_next;

    logic [SIZE_BITS-1:0] image_width_reg, image_width_next;
    logic [SIZE_BITS-1:0] image_height_reg, image_height_next;
    logic [FOV_BITS-1:0]  fov_h_reg, fov_h_next;
    logic [FOV_BITS-1:0]  fov_v_reg, fov_v_next;

    logic                  tracking_on_reg, tracking_on_next;
    logic                  lock_valid_reg, lock_valid_next;
    logic [ID_BITS-1:0]    locked_id_reg, locked_id_next;
    logic [DIST_W-1:0]     best_dist_reg, best_dist_next;
    logic [ID_BITS-1:0]    cand_id_reg, cand_id_next;
    logic                  frame_hit_reg, frame_hit_next;
    logic [COORD_BITS-1:0] held_x_reg, held_x_next;
    logic [COORD_BITS-1:0] held_y_reg, held_y_next;

    logic [ID_BITS-1:0]    det_id_reg, det_id_next;
    logic [COORD_BITS-1:0] det_x_reg, det_x_next;
    logic [COORD_BITS-1:0] det_y_reg, det_y_next;
    logic                  det_last_reg, det_last_next;
    logic [OFF_W-1:0]      dx_reg, dx_next;
    logic [OFF_W-1:0]      dy_reg, dy_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic [ANGLE_BITS-1:0] ax_reg, ax_next;
    logic [ANGLE_BITS-1:0] ay_reg, ay_next;

    logic                  out_valid_reg, out_valid_next;
    logic [ANGLE_BITS-1:0] angle_x_reg, angle_x_next;
    logic [ANGLE_BITS-1:0] angle_y_reg, angle_y_next;

    logic [MAG_BITS-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]     mul_p;

    logic                  div_start;
    logic [DIVD_W-1:0]     div_dividend;
    logic [SIZE_BITS-1:0]  div_divisor;
    logic [DIVD_W-1:0]     div_quotient;
    div_status_t           div_status;

    logic [15:0]           w8, h8;
    logic [SIZE_BITS-1:0]  w_eff, h_eff;
    logic [OFF_W-1:0]      ox, oy;
    logic [MAG_BITS-1:0]   dx_abs, dy_abs, ox_abs, oy_abs;
    logic [DIST_W-1:0]     d2;
    logic                  better;
    logic                  hit_now;
    logic [NUM_W-1:0]      num_sum;
    logic [15:0]           q_sat;
    logic [ANGLE_BITS-1:0] q_mag;

    assign w8     = {image_width_reg, 3'b000};
    assign h8     = {image_height_reg, 3'b000};
    assign w_eff  = (image_width_reg == '0) ? SIZE_BITS'(1) : image_width_reg;
    assign h_eff  = (image_height_reg == '0) ? SIZE_BITS'(1) : image_height_reg;
    assign ox     = OFF_W'(held_x_reg) - OFF_W'(w8);
    assign oy     = OFF_W'(h8) - OFF_W'(held_y_reg);
    assign dx_abs = dx_reg[OFF_W-1] ? MAG_BITS'(-dx_reg) : MAG_BITS'(dx_reg);
    assign dy_abs = dy_reg[OFF_W-1] ? MAG_BITS'(-dy_reg) : MAG_BITS'(dy_reg);
    assign ox_abs = ox[OFF_W-1] ? MAG_BITS'(-ox) : MAG_BITS'(ox);
    assign oy_abs = oy[OFF_W-1] ? MAG_BITS'(-oy) : MAG_BITS'(oy);
    assign d2     = DIST_W'(acc_reg) + DIST_W'(mul_p);
    assign better = d2 < best_dist_reg;
    assign hit_now = !frame_hit_reg && (track_id == locked_id_reg);
    assign q_sat  = (div_quotient > DIVD_W'(ANGLE_MAX)) ? ANGLE_MAX : div_quotient[15:0];
    assign q_mag  = ANGLE_BITS'(q_sat);

    tlat_mul #(
        .WIDTH (MAG_BITS)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    tlat_div #(
        .N_WIDTH (DIVD_W),
        .D_WIDTH (SIZE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // shared unit operand selection
    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_divisor  = w_eff;
        num_sum      = NUM_W'(mul_p[MAG_BITS+15:0]) + NUM_W'({w_eff, 3'b000});
        unique case (state_reg)
            S_SQ_X:
            begin
                mul_a = dx_abs;
                mul_b = dx_abs;
            end
            S_SQ_Y:
            begin
                mul_a = dy_abs;
                mul_b = dy_abs;
            end
            S_MUL_X:
            begin
                mul_a = ox_abs;
                mul_b = MAG_BITS'(fov_h_reg);
            end
            S_MUL_Y:
            begin
                mul_a = oy_abs;
                mul_b = MAG_BITS'(fov_v_reg);
            end
            S_START_X:
            begin
                div_start = 1'b1;
            end
            S_START_Y:
            begin
                div_start   = 1'b1;
                div_divisor = h_eff;
                num_sum     = NUM_W'(mul_p[MAG_BITS+15:0]) + NUM_W'({h_eff, 3'b000});
            end
            default:
            begin
            end
        endcase
        // rounding half of 16*size, then the factor 16 comes off as a shift
        div_dividend = num_sum[NUM_W-1:4];
    end

    // sequencer and state update
    always_comb
    begin
        state_next        = state_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        fov_h_next        = fov_h_reg;
        fov_v_next        = fov_v_reg;
        tracking_on_next  = tracking_on_reg;
        lock_valid_next   = lock_valid_reg;
        locked_id_next    = locked_id_reg;
        best_dist_next    = best_dist_reg;
        cand_id_next      = cand_id_reg;
        frame_hit_next    = frame_hit_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        det_id_next       = det_id_reg;
        det_x_next        = det_x_reg;
        det_y_next        = det_y_reg;
        det_last_next     = det_last_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        acc_next          = acc_reg;
        ax_next           = ax_reg;
        ay_next           = ay_reg;
        angle_x_next      = angle_x_reg;
        angle_y_next      = angle_y_reg;
        out_valid_next    = out_valid_reg && out_stall;

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:    image_width_next  = cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT:   image_height_next = cfg_data[SIZE_BITS-1:0];
                CFG_FOV_HORIZONTAL: fov_h_next        = cfg_data[FOV_BITS-1:0];
                CFG_FOV_VERTICAL:   fov_v_next        = cfg_data[FOV_BITS-1:0];
                default:            image_width_next  = image_width_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation)
                    begin
                        if (cmd_has_value && ($unsigned(cmd_word) == ENABLE_WORD))
                        begin
                            tracking_on_next = 1'b1;
                            lock_valid_next  = 1'b0;
                            best_dist_next   = DIST_W'(DIST_LIMIT);
                            cand_id_next     = '0;
                            frame_hit_next   = 1'b0;
                        end
                    end
                    else if (tracking_on_reg)
                    begin
                        if (!lock_valid_reg)
                        begin
                            if (is_drone)
                            begin
                                det_id_next   = track_id;
                                det_x_next    = center_x;
                                det_y_next    = center_y;
                                det_last_next = last_in_frame;
                                dx_next       = OFF_W'(center_x) - OFF_W'(w8);
                                dy_next       = OFF_W'(center_y) - OFF_W'(h8);
                                state_next    = S_SQ_X;
                            end
                            else if (last_in_frame)
                            begin
                                if (frame_hit_reg)
                                begin
                                    lock_valid_next = 1'b1;
                                    locked_id_next  = cand_id_reg;
                                end
                                best_dist_next = DIST_W'(DIST_LIMIT);
                                cand_id_next   = '0;
                                frame_hit_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (hit_now)
                            begin
                                held_x_next    = center_x;
                                held_y_next    = center_y;
                                frame_hit_next = 1'b1;
                            end
                            if (last_in_frame)
                            begin
                                if (frame_hit_reg || hit_now)
                                begin
                                    state_next = S_MUL_X;
                                end
                                else
                                begin
                                    lock_valid_next = 1'b0;
                                end
                                best_dist_next = DIST_W'(DIST_LIMIT);
                                cand_id_next   = '0;
                                frame_hit_next = 1'b0;
                            end
                        end
                    end
                end
            end
            S_SQ_X:
            begin
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                acc_next   = mul_p;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (better)
                begin
                    best_dist_next = d2;
                    cand_id_next   = det_id_reg;
                    held_x_next    = det_x_reg;
                    held_y_next    = det_y_reg;
                    frame_hit_next = 1'b1;
                end
                if (det_last_reg)
                begin
                    if (frame_hit_reg || better)
                    begin
                        lock_valid_next = 1'b1;
                        locked_id_next  = better ? det_id_reg : cand_id_reg;
                    end
                    best_dist_next = DIST_W'(DIST_LIMIT);
                    cand_id_next   = '0;
                    frame_hit_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            S_MUL_X:
            begin
                state_next = S_START_X;
            end
            S_START_X:
            begin
                state_next = S_DIV_X;
            end
            S_DIV_X:
            begin
                if (div_status.done)
                begin
                    ax_next    = ox[OFF_W-1] ? -q_mag : q_mag;
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                state_next = S_START_Y;
            end
            S_START_Y:
            begin
                state_next = S_DIV_Y;
            end
            S_DIV_Y:
            begin
                if (div_status.done)
                begin
                    ay_next    = oy[OFF_W-1] ? -q_mag : q_mag;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    angle_x_next   = ax_reg;
                    angle_y_next   = ay_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            fov_h_reg        <= FOV_H_RESET;
            fov_v_reg        <= FOV_V_RESET;
            tracking_on_reg  <= 1'b0;
            lock_valid_reg   <= 1'b0;
            locked_id_reg    <= '0;
            best_dist_reg    <= DIST_W'(DIST_LIMIT);
            cand_id_reg      <= '0;
            frame_hit_reg    <= 1'b0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            fov_h_reg        <= fov_h_next;
            fov_v_reg        <= fov_v_next;
            tracking_on_reg  <= tracking_on_next;
            lock_valid_reg   <= lock_valid_next;
            locked_id_reg    <= locked_id_next;
            best_dist_reg    <= best_dist_next;
            cand_id_reg      <= cand_id_next;
            frame_hit_reg    <= frame_hit_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        det_id_reg   <= det_id_next;
        det_x_reg    <= det_x_next;
        det_y_reg    <= det_y_next;
        det_last_reg <= det_last_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        acc_reg      <= acc_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        angle_x_reg  <= angle_x_next;
        angle_y_reg  <= angle_y_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign angle_x   = angle_x_reg;
    assign angle_y   = angle_y_reg;

`ifndef SYNTH
    a_lock_needs_tracking: assert property (@(posedge clk) disable iff (!rst_n)
        lock_valid_reg |-> tracking_on_reg)
        else $error("lock held while tracking is off");

    a_unlocked_hit_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_hit_reg && !lock_valid_reg) |-> (best_dist_reg < DIST_W'(DIST_LIMIT)))
        else $error("candidate recorded without beating the distance limit");

    a_command_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation) |=> (state_reg == S_IDLE))
        else $error("command beat left the sequencer busy");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && (!out_valid_reg || !out_stall)) |=> out_valid_reg)
        else $error("finished angles not loaded into the output register");

    a_div_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_START_X || state_reg == S_START_Y) |-> !div_status.busy)
        else $error("divider restarted while busy");
`endif

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the target lock angle tracker top level
`timescale 1ns / 1ps

module testbench;
    import tlat_pkg::*;

    localparam logic OP_DETECTION  = 1'b0;
    localparam logic OP_COMMAND    = 1'b1;
    localparam int   IDLE_PCT      = 18;
    localparam int   SETTLE_CYCLES = 100;
    localparam int   STUCK_LIMIT   = 5000;

    typedef struct packed {
        logic        operation;
        logic        cmd_has_value;
        logic [31:0] cmd_word;
        logic        is_drone;
        logic [15:0] track_id;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic        last_in_frame;
    } beat_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] ax;
        logic signed [ANGLE_BITS-1:0] ay;
    } angle_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic cmd_has_value = 1'b0;
    logic signed [CMD_BITS-1:0] cmd_word = '0;
    logic is_drone = 1'b0;
    logic [15:0] track_id = '0;
    logic [15:0] center_x = '0;
    logic [15:0] center_y = '0;
    logic last_in_frame = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;

    target_lock_angle_tracker_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .cmd_has_value (cmd_has_value),
        .cmd_word      (cmd_word),
        .is_drone      (is_drone),
        .track_id      (track_id),
        .center_x      (center_x),
        .center_y      (center_y),
        .last_in_frame (last_in_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .angle_x       (angle_x),
        .angle_y       (angle_y)
    );

    always #5 clk = ~clk;

    beat_t       beat_q[$];
    angle_pair_t angle_q[$];
    beat_t       on_port;
    int          beats_queued = 0;
    int          beats_taken = 0;
    int          mismatches = 0;
    int          stuck_cycles = 0;
    logic        steady = 1'b0;
    logic [15:0] id_pool[4];

    // tracker copy: settings and lock state
    logic [SIZE_BITS-1:0] img_w = WIDTH_RESET;
    logic [SIZE_BITS-1:0] img_h = HEIGHT_RESET;
    logic [FOV_BITS-1:0]  fov_h = FOV_H_RESET;
    logic [FOV_BITS-1:0]  fov_v = FOV_V_RESET;
    logic                 tracking_on = 1'b0;
    logic                 lock_valid = 1'b0;
    logic                 frame_hit = 1'b0;
    logic [15:0]          locked_id = '0;
    logic [15:0]          cand_id = '0;
    logic [15:0]          held_x = '0;
    logic [15:0]          held_y = '0;
    longint unsigned      best_dist = DIST_LIMIT;

    function automatic logic signed [ANGLE_BITS-1:0] scale_offset(input longint off,
            input longint unsigned fov, input longint unsigned size);
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        den = 16 * ((size == 0) ? 1 : size);
        mag = (off < 0) ? -off : off;
        mag = mag * fov;
        q = (mag + den / 2) / den;
        if (q > ANGLE_MAX)
            q = ANGLE_MAX;
        scale_offset = (off < 0) ? -$signed(q[ANGLE_BITS-1:0]) : $signed(q[ANGLE_BITS-1:0]);
    endfunction

    task automatic clear_search;
        best_dist = DIST_LIMIT;
        cand_id = '0;
        frame_hit = 1'b0;
    endtask

    task automatic advance_tracker(input beat_t b);
        longint          dx;
        longint          dy;
        longint unsigned d2;
        angle_pair_t     res;
        if (b.operation == OP_COMMAND) begin
            if (b.cmd_has_value && b.cmd_word == ENABLE_WORD) begin
                tracking_on = 1'b1;
                lock_valid = 1'b0;
                clear_search();
            end
        end else if (tracking_on) begin
            if (!lock_valid) begin
                if (b.is_drone) begin
                    dx = longint'(b.center_x) - 8 * longint'(img_w);
                    dy = longint'(b.center_y) - 8 * longint'(img_h);
                    d2 = dx * dx + dy * dy;
                    // strictly smaller, so the earliest of equals stays
                    if (d2 < best_dist) begin
                        best_dist = d2;
                        cand_id = b.track_id;
                        held_x = b.center_x;
                        held_y = b.center_y;
                        frame_hit = 1'b1;
                    end
                end
                if (b.last_in_frame) begin
                    if (frame_hit) begin
                        lock_valid = 1'b1;
                        locked_id = cand_id;
                    end
                    clear_search();
                end
            end else begin
                if (!frame_hit && b.track_id == locked_id) begin
                    held_x = b.center_x;
                    held_y = b.center_y;
                    frame_hit = 1'b1;
                end
                if (b.last_in_frame) begin
                    if (frame_hit) begin
                        dx = longint'(held_x) - 8 * longint'(img_w);
                        dy = 8 * longint'(img_h) - longint'(held_y);
                        res.ax = scale_offset(dx, fov_h, img_w);
                        res.ay = scale_offset(dy, fov_v, img_h);
                        angle_q.push_back(res);
                    end else begin
                        lock_valid = 1'b0;
                    end
                    clear_search();
                end
            end
        end
    endtask

    // input driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                advance_tracker(on_port);
                beats_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (beat_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_port = beat_q.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= on_port.operation;
                    cmd_has_value <= on_port.cmd_has_value;
                    cmd_word      <= on_port.cmd_word;
                    is_drone      <= on_port.is_drone;
                    track_id      <= on_port.track_id;
                    center_x      <= on_port.center_x;
                    center_y      <= on_port.center_y;
                    last_in_frame <= on_port.last_in_frame;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        angle_pair_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (angle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected angle beat: x %0d y %0d", angle_x, angle_y);
            end else begin
                want = angle_q.pop_front();
                if (angle_x !== want.ax || angle_y !== want.ay) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("angle beat: expected x %0d y %0d, got x %0d y %0d",
                                 want.ax, want.ay, angle_x, angle_y);
                end
            end
        end
        out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("target_lock_angle_tracker_unit: mismatch");
        $finish;
    end

    task automatic add_command(input logic has_value, input logic [31:0] word);
        beat_t b;
        b = {$urandom, $urandom, $urandom};
        b.operation = OP_COMMAND;
        b.cmd_has_value = has_value;
        b.cmd_word = word;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    task automatic add_detection(input logic drone, input logic [15:0] id,
            input logic [15:0] x, input logic [15:0] y, input logic last);
        beat_t b;
        b = {$urandom, $urandom, $urandom};
        b.operation = OP_DETECTION;
        b.is_drone = drone;
        b.track_id = id;
        b.center_x = x;
        b.center_y = y;
        b.last_in_frame = last;
        beat_q.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [15:0] pick_coord(input int centre);
        logic [31:0] r;
        r = $urandom;
        if (r[31])
            return r[15:0];
        r = centre + $urandom_range(0, 4095) - 2048;
        return r[15:0];
    endfunction

    task automatic random_frames(input int count);
        int          start;
        int          n_det;
        logic [31:0] r;
        logic [15:0] id;
        start = beats_queued;
        for (int i = 0; i < 4; i++)
            id_pool[i] = $urandom;
        while (beats_queued - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                add_command(1'b1, ENABLE_WORD);
            end else if (r < 8) begin
                // commands that must do nothing
                case ($urandom_range(0, 2))
                    0: add_command(1'b0, ENABLE_WORD);
                    1: add_command(1'b1, ENABLE_WORD ^ (32'd1 << $urandom_range(0, 31)));
                    default: add_command($urandom_range(0, 1), $urandom);
                endcase
            end else begin
                n_det = $urandom_range(1, 5);
                for (int k = 0; k < n_det; k++) begin
                    r = $urandom;
                    id = (r[6:0] < 110) ? id_pool[r[8:7]] : r[31:16];
                    // now and then a frame runs on without its end mark
                    add_detection($urandom_range(0, 99) < 70, id,
                                  pick_coord(8 * img_w), pick_coord(8 * img_h),
                                  k == n_det - 1 && $urandom_range(0, 99) >= 5);
                end
            end
        end
    endtask

    task automatic drain;
        while (beats_taken != beats_queued || angle_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_IMAGE_WIDTH:    img_w = val[SIZE_BITS-1:0];
            CFG_IMAGE_HEIGHT:   img_h = val[SIZE_BITS-1:0];
            CFG_FOV_HORIZONTAL: fov_h = val;
            CFG_FOV_VERTICAL:   fov_v = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] w, input logic [15:0] h,
            input logic [15:0] fh, input logic [15:0] fv);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_FOV_HORIZONTAL, fh);
        write_reg(CFG_FOV_VERTICAL, fv);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] cx0;
        logic [15:0] cy0;
        cx0 = 16'd10240;
        cy0 = 16'd5760;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats at the reset settings
        add_detection(1'b1, 16'd7, cx0, cy0, 1'b1);      // tracking still off
        add_command(1'b0, ENABLE_WORD);                 // word without its flag
        add_command(1'b1, ENABLE_WORD + 1);
        add_command(1'b1, 32'h8000_0000);
        add_detection(1'b1, 16'd7, cx0, cy0, 1'b1);
        add_command(1'b1, ENABLE_WORD);
        add_detection(1'b0, 16'd6, cx0, cy0, 1'b1);      // no target in frame
        add_detection(1'b1, 16'd5, 16'h0000, 16'h0000, 1'b0);
        add_detection(1'b0, 16'd6, cx0, cy0, 1'b0);
        add_detection(1'b1, 16'd7, cx0, cy0, 1'b0);
        add_detection(1'b1, 16'd9, cx0, cy0, 1'b1);      // equal distance, earlier wins
        add_detection(1'b1, 16'd3, cx0, cy0, 1'b0);
        add_detection(1'b0, 16'd7, 16'hFFFF, 16'h0000, 1'b0);
        add_detection(1'b1, 16'd7, cx0, cy0, 1'b1);
        add_detection(1'b1, 16'd7, 16'h0000, 16'hFFFF, 1'b1);
        add_detection(1'b1, 16'd7, cx0, cy0, 1'b0);
        add_command(1'b1, ENABLE_WORD);                 // enable in mid-frame
        add_detection(1'b1, 16'd11, cx0 + 16, cy0 - 16, 1'b1);
        add_detection(1'b1, 16'd12, cx0, cy0, 1'b1);     // miss drops the lock
        add_detection(1'b1, 16'hFFFF, cx0, cy0, 1'b1);
        add_detection(1'b0, 16'hFFFF, cx0, cy0, 1'b1);
        add_command(1'b1, 32'h7FFF_FFFF);
        add_detection(1'b1, 16'hFFFF, cx0 + 8, cy0, 1'b1); // half rounds away from zero
        random_frames(60);
        drain();

        load_settings(16'd1, 16'd1, 16'd0, 16'd0);
        random_frames(85);
        drain();

        load_settings(16'd4096, 16'd4096, 16'd46080, 16'd46080);
        steady = 1'b1;
        random_frames(85);
        drain();
        steady = 1'b0;

        // zero size is taken as one
        load_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        random_frames(85);
        drain();

        load_settings(16'hFFFF, 16'd8191, $urandom, $urandom);
        random_frames(85);
        drain();

        for (int p = 0; p < 4; p++) begin
            load_settings($urandom_range(1, 4096), $urandom_range(1, 4096),
                          $urandom_range(0, 46080), $urandom_range(0, 46080));
            random_frames(85);
            drain();
        end

        if (mismatches == 0 && angle_q.size() == 0)
            $display("target_lock_angle_tracker_unit: match");
        else
            $display("target_lock_angle_tracker_unit: mismatch");
        $finish;
    end

endmodule
